### design/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define SFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned MaxPatternDef     = 8;
  localparam int unsigned MaxReplacementDef = 8;

  localparam int unsigned CharW    = 8;
  localparam int unsigned LenW     = 4;
  localparam int unsigned TallyW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [TallyW-1:0] TallyMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_TEXT       = 3'd0,
    CFG_PATTERN_LENGTH     = 3'd1,
    CFG_REPLACEMENT_TEXT   = 3'd2,
    CFG_REPLACEMENT_LENGTH = 3'd3,
    CFG_MATCH_EXACT_CASE   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             text_end;
  } in_word_t;

  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic              char_present;
    logic              run_end;
    logic [TallyW-1:0] replacements_made;
  } out_word_t;

  // side info shared by every word of one burst
  typedef struct packed {
    logic              present;
    logic              last;
    logic [TallyW-1:0] tally;
  } burst_meta_t;

  // ascii upper case folds to lower case unless exact compare is on
  function automatic logic [CharW-1:0] fold_char(logic [CharW-1:0] ch, logic exact);
    logic [CharW-1:0] res;
    res = ch;
    if (!exact && (ch >= 8'h41) && (ch <= 8'h5A)) begin
      res = ch + 8'h20;
    end
    return res;
  endfunction

endpackage

### design/sfr_cell.sv
module sfr_cell
  import sfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             load_i,
  input  logic             shift_i,
  input  logic [CharW-1:0] char_i,
  input  logic [CharW-1:0] nbr_char_i,
  input  logic [CharW-1:0] pat_char_i,
  input  logic             exact_i,
  output logic [CharW-1:0] eff_char_o,
  output logic             match_o
);

  logic [CharW-1:0] char_q;
  logic [CharW-1:0] char_d;

  // the incoming character lands in the cell at the fill position
  assign eff_char_o = load_i ? char_i : char_q;
  assign match_o    = (fold_char(eff_char_o, exact_i) == fold_char(pat_char_i, exact_i));
  assign char_d     = shift_i ? nbr_char_i : eff_char_o;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      char_q <= char_d;
    end
  end

endmodule

### design/sfr_burst.sv
`include "assert_macros.svh"

module sfr_burst
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_RESULTS = MaxPatternDef,
  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic [MAX_RESULTS-1:0][CharW-1:0]  chars_i,
  input  logic [CntW-1:0]                    cnt_i,
  input  burst_meta_t                        meta_i,
  output logic                               ready_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output out_word_t                          out_word_o
);

  logic [MAX_RESULTS-1:0][CharW-1:0] buf_q;
  logic [CntW-1:0]                   cnt_q;
  burst_meta_t                       meta_q;
  logic                              out_valid_q;
  out_word_t                         out_q;
  logic                              pop;

  // head word moves into the output register whenever that register is free
  assign pop     = (cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign ready_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_i;
    end else if (pop) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q  <= chars_i;
      meta_q <= meta_i;
    end else if (pop) begin
      for (int j = 0; j < MAX_RESULTS - 1; j++) begin
        buf_q[j] <= buf_q[j+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q.out_char          <= buf_q[0];
      out_q.char_present      <= meta_q.present;
      out_q.run_end           <= meta_q.last && (cnt_q == CntW'(1));
      out_q.replacements_made <= meta_q.tally;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `SFR_ASSERT(a_no_overwrite, clk_i, rst_ni, !load_i || ready_o, "burst loaded while words remain")
  `SFR_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CntW'(MAX_RESULTS), "burst count out of range")

endmodule

### design/stream_find_replace_all_top.sv
// Streaming find-and-replace-all over 8-bit characters. Every leftmost,
// non-overlapping match of the pattern (1 to MAX_PATTERN characters, exact or
// ASCII case-folded) is replaced by the replacement (0 to MAX_REPLACEMENT
// characters). The match window is a row of character cells: the new character
// drops into the cell at the fill position, each cell compares its character
// with its pattern byte, and on a miss with a full window every cell takes its
// neighbor's value. An item is taken every cycle while each character yields at
// most one output word; one that yields more (a replacement or the text_end
// flush) holds the input until the burst queue, draining one word per cycle,
// pops its last word. An item whose words all wait behind a stalled output keeps
// the input stalled. text_end flushes the window, marks the last word with
// run_end (a bare word with char_present low if nothing else goes out) and
// clears the window and the match count, which saturates at 65535. Configuration
// must be written through the cfg port only while the block is idle; the block
// does not enforce it. cfg_ready_o is always high, unused indexes are ignored.
`include "assert_macros.svh"

module stream_find_replace_all_top
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PATTERN     = MaxPatternDef,
  parameter int unsigned MAX_REPLACEMENT = MaxReplacementDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned MaxResults = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                                      : MAX_REPLACEMENT;
  localparam int unsigned RepBytes   = (MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1;
  localparam int unsigned FillW      = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  // configuration registers
  logic [MAX_PATTERN*CharW-1:0] pattern_text_q;
  logic [LenW-1:0]              pattern_length_q;
  logic [RepBytes*CharW-1:0]    replacement_text_q;
  logic [LenW-1:0]              replacement_length_q;
  logic                         match_exact_case_q;

  // window control and match count
  logic [FillW-1:0]  fill_q, fill_d;
  logic [TallyW-1:0] tally_q, tally_d;

  logic [FillW-1:0] plen;
  logic [CntW-1:0]  rlen;
  logic [FillW-1:0] fill_inc;
  logic             accept;
  logic             full;
  logic             hit;
  logic             shift;
  logic             burst_ready;
  logic             burst_load;
  logic [CntW-1:0]  burst_cnt;
  burst_meta_t      burst_meta;
  logic [TallyW-1:0] tally_step;

  logic [MAX_PATTERN-1:0][CharW-1:0] eff_char;
  logic [MAX_PATTERN-1:0]            cell_match;
  logic [MaxResults-1:0][CharW-1:0]  rep_chars;
  logic [MaxResults-1:0][CharW-1:0]  win_chars;
  logic [MaxResults-1:0][CharW-1:0]  burst_chars;

  // ---------------------------------------------------------------------------
  // configuration port, never busy
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_text_q       <= '0;
      pattern_length_q     <= LenW'(1);
      replacement_text_q   <= '0;
      replacement_length_q <= '0;
      match_exact_case_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_TEXT:       pattern_text_q       <= cfg_data_i[MAX_PATTERN*CharW-1:0];
        CFG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data_i[LenW-1:0];
        CFG_REPLACEMENT_TEXT:   replacement_text_q   <= cfg_data_i[RepBytes*CharW-1:0];
        CFG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data_i[LenW-1:0];
        CFG_MATCH_EXACT_CASE:   match_exact_case_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // lengths clamped into the supported range, zero pattern length acts as one
  always_comb begin
    if (pattern_length_q == '0) begin
      plen = FillW'(1);
    end else if (pattern_length_q > LenW'(MAX_PATTERN)) begin
      plen = FillW'(MAX_PATTERN);
    end else begin
      plen = FillW'(pattern_length_q);
    end
    if (replacement_length_q > LenW'(MAX_REPLACEMENT)) begin
      rlen = CntW'(MAX_REPLACEMENT);
    end else begin
      rlen = CntW'(replacement_length_q);
    end
  end

  // ---------------------------------------------------------------------------
  // input handshake: take a word once the burst queue is free for its results
  // ---------------------------------------------------------------------------
  assign in_stall_o = !burst_ready;
  assign accept     = in_valid_i && burst_ready;

  // ---------------------------------------------------------------------------
  // row of window cells
  // ---------------------------------------------------------------------------
  assign fill_inc = fill_q + FillW'(1);
  assign full     = (fill_inc >= plen);

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [CharW-1:0] nbr_char;
    if (i == MAX_PATTERN - 1) begin : g_tail
      // nothing beyond the last cell, it only matters past the fill
      assign nbr_char = eff_char[i];
    end else begin : g_body
      assign nbr_char = eff_char[i+1];
    end

    sfr_cell u_cell (
      .clk_i      (clk_i),
      .en_i       (accept),
      .load_i     (fill_q == FillW'(i)),
      .shift_i    (shift),
      .char_i     (in_word_i.text_char),
      .nbr_char_i (nbr_char),
      .pat_char_i (pattern_text_q[i*CharW +: CharW]),
      .exact_i    (match_exact_case_q),
      .eff_char_o (eff_char[i]),
      .match_o    (cell_match[i])
    );
  end

  // match over the oldest plen cells
  always_comb begin
    hit = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FillW'(i) < plen) begin
        hit = hit & cell_match[i];
      end
    end
  end

  // on a miss with a full window the oldest character leaves and the rest move up
  assign shift = full && !hit && !in_word_i.text_end;

  always_comb begin
    if (hit || in_word_i.text_end) begin
      fill_d = '0;
    end else if (shift) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_inc;
    end
  end

  // ---------------------------------------------------------------------------
  // match count
  // ---------------------------------------------------------------------------
  assign tally_step = (hit && (tally_q != TallyMax)) ? tally_q + TallyW'(1) : tally_q;
  assign tally_d    = in_word_i.text_end ? '0 : tally_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      tally_q <= '0;
    end else if (accept) begin
      fill_q  <= fill_d;
      tally_q <= tally_d;
    end
  end

  // ---------------------------------------------------------------------------
  // words caused by this character
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < MaxResults; j++) begin : g_slot
    if (j < MAX_REPLACEMENT) begin : g_rep
      assign rep_chars[j] = replacement_text_q[j*CharW +: CharW];
    end else begin : g_rep_pad
      assign rep_chars[j] = '0;
    end
    if (j < MAX_PATTERN) begin : g_win
      assign win_chars[j] = eff_char[j];
    end else begin : g_win_pad
      assign win_chars[j] = '0;
    end
  end

  always_comb begin
    burst_chars        = win_chars;
    burst_cnt          = '0;
    burst_meta.present = 1'b1;
    burst_meta.last    = in_word_i.text_end;
    burst_meta.tally   = tally_step;
    if (hit) begin
      // replacement, window gone so nothing to flush
      burst_chars = rep_chars;
      burst_cnt   = rlen;
    end else if (in_word_i.text_end) begin
      // flush the whole window, oldest first
      burst_cnt = CntW'(fill_inc);
    end else if (full) begin
      burst_cnt = CntW'(1);
    end
    // end of text with nothing to send: bare end marker
    if (in_word_i.text_end && (burst_cnt == '0)) begin
      burst_chars        = '0;
      burst_cnt          = CntW'(1);
      burst_meta.present = 1'b0;
    end
  end

  assign burst_load = accept && (burst_cnt != '0);

  sfr_burst #(
    .MAX_RESULTS (MaxResults)
  ) u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (burst_load),
    .chars_i     (burst_chars),
    .cnt_i       (burst_cnt),
    .meta_i      (burst_meta),
    .ready_o     (burst_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  `SFR_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q < FillW'(MAX_PATTERN), "window fill too large")
  `SFR_ASSERT_NEXT(a_end_clears, clk_i, rst_ni, accept && in_word_i.text_end, (fill_q == '0) && (tally_q == '0), "state not cleared after end")

endmodule

### verif/tb_stream_find_replace_all_top.sv
module tb_stream_find_replace_all_top;
  import sfr_pkg::*;

  // spare register indexes, writes there must leave every setting alone
  localparam logic [CfgIdxW-1:0] CfgSpareIdx    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareTopIdx = 3'd7;

  localparam int unsigned ClkPeriod    = 20;
  localparam int unsigned ResetCycles  = 7;
  localparam int unsigned IdlePct      = 8;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned RandomItems  = 145;
  localparam int unsigned LimitCycles  = 1000000;
  localparam int unsigned MaxReports   = 40;

  // rewrite predictor: own copy of the settings, the match window and the tally,
  // plus the queue of words the block still owes us
  class rewrite_scoreboard;
    logic [CfgDataW-1:0] pat_text;
    logic [LenW-1:0]     pat_len;
    logic [CfgDataW-1:0] rep_text;
    logic [LenW-1:0]     rep_len;
    logic                exact;
    logic [CharW-1:0]    window [MaxPatternDef];
    int unsigned         fill;
    logic [TallyW-1:0]   tally;
    out_word_t           rewritten_q[$];
    int unsigned         errors;
    int unsigned         words_checked;
    int unsigned         match_cnt;
    int unsigned         texts;

    function new();
      pat_text = '0;
      pat_len  = 4'd1;
      rep_text = '0;
      rep_len  = '0;
      exact    = 1'b0;
      fill     = 0;
      tally    = '0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_PATTERN_TEXT:       pat_text = data;
        CFG_PATTERN_LENGTH:     pat_len  = data[LenW-1:0];
        CFG_REPLACEMENT_TEXT:   rep_text = data;
        CFG_REPLACEMENT_LENGTH: rep_len  = data[LenW-1:0];
        CFG_MATCH_EXACT_CASE:   exact    = data[0];
        default: ;
      endcase
    endfunction

    // length in use: zero reads as one, anything past the window as full window
    function int unsigned active_pattern_len();
      if (pat_len == 0) return 1;
      if (pat_len > MaxPatternDef) return MaxPatternDef;
      return pat_len;
    endfunction

    function logic [CharW-1:0] fold_letter(logic [CharW-1:0] c);
      if (!exact && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
      return c;
    endfunction

    function out_word_t make_word(logic [CharW-1:0] c, logic present);
      out_word_t w;
      w.out_char          = c;
      w.char_present      = present;
      w.run_end           = 1'b0;
      w.replacements_made = tally;
      return w;
    endfunction

    // one accepted text character: works out every word it causes
    function void take_char(in_word_t w);
      out_word_t   burst[$];
      out_word_t   tail;
      int unsigned plen;
      int unsigned rlen;
      int unsigned i;
      bit          hit;
      plen = active_pattern_len();
      rlen = (rep_len > MaxReplacementDef) ? MaxReplacementDef : rep_len;
      window[fill] = w.text_char;
      fill++;
      if (fill >= plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (fold_letter(window[i]) != fold_letter(pat_text[8*i +: 8])) hit = 1'b0;
        end
        if (hit) begin
          match_cnt++;
          if (tally != TallyMax) tally++;
          for (i = 0; i < rlen; i++) begin
            burst.push_back(make_word(rep_text[8*i +: 8], 1'b1));
          end
          // anything buffered past the pattern goes too
          fill = 0;
        end else begin
          burst.push_back(make_word(window[0], 1'b1));
          for (i = 1; i < fill; i++) begin
            window[i-1] = window[i];
          end
          fill--;
        end
      end
      if (w.text_end) begin
        for (i = 0; i < fill; i++) begin
          burst.push_back(make_word(window[i], 1'b1));
        end
        fill = 0;
        if (burst.size() == 0) burst.push_back(make_word(8'h00, 1'b0));
        tail = burst.pop_back();
        tail.run_end = 1'b1;
        burst.push_back(tail);
        tally = '0;
        texts++;
      end
      foreach (burst[k]) rewritten_q.push_back(burst[k]);
    endfunction

    function void flag(string field, logic [TallyW-1:0] want, logic [TallyW-1:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      words_checked++;
      if (rewritten_q.size() == 0) begin
        flag("unexpected word", '0, {got.out_char, 8'h00});
        return;
      end
      want = rewritten_q.pop_front();
      if (got.out_char !== want.out_char) begin
        flag("out_char", TallyW'(want.out_char), TallyW'(got.out_char));
      end
      if (got.char_present !== want.char_present) begin
        flag("char_present", TallyW'(want.char_present), TallyW'(got.char_present));
      end
      if (got.run_end !== want.run_end) begin
        flag("run_end", TallyW'(want.run_end), TallyW'(got.run_end));
      end
      if (got.replacements_made !== want.replacements_made) begin
        flag("replacements_made", want.replacements_made, got.replacements_made);
      end
    endfunction

    function int unsigned pending();
      return rewritten_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_word_t            in_word_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_word_t           out_word_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rewrite_scoreboard sb;
  bit                calm;        // no idling on either side while set
  bit                hold_req;    // asks the sink for one long hold-off
  int unsigned       items_sent;

  stream_find_replace_all_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // every word leaving the block is checked at the edge that takes it
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(out_word_o);
  end

  // sink: random stalls, one long hold-off on request, none in calm stretches
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
      end
    end
  end

  // write one register, valid drops again right after the handshake edge
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one text word, with random idle cycles ahead of it
  task automatic send_char(input logic [CharW-1:0] ch, input logic is_last);
    in_word_t w;
    w.text_char = ch;
    w.text_end  = is_last;
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_char(w);
    items_sent++;
  endtask

  // wait until every owed word is out, then let a character with no output finish
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // small alphabet so matches and near misses are common; includes the
  // characters just outside the upper and lower case ranges
  function automatic logic [CharW-1:0] pick_alpha();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h40;
      3: return 8'h5B;
      4: return 8'h60;
      5: return 8'h7B;
      default: return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(2));
    endcase
  endfunction

  // flip letter case, mostly when folding is on so the flips still match
  function automatic logic [CharW-1:0] vary_case(logic [CharW-1:0] c);
    bit letter;
    letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    if (letter && $urandom_range(99) < (sb.exact ? 15 : 50)) return c ^ 8'h20;
    return c;
  endfunction

  // often whole pattern copies, some cut short, the rest noise
  task automatic send_random_text(input int unsigned len);
    logic [CharW-1:0] chars[$];
    int unsigned      plen;
    int unsigned      cut;
    int unsigned      i;
    plen = sb.active_pattern_len();
    while (chars.size() < len) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          for (i = 0; i < plen; i++) chars.push_back(vary_case(sb.pat_text[8*i +: 8]));
        end
        4, 5: begin
          cut = $urandom_range(plen - 1);
          for (i = 0; i < cut; i++) chars.push_back(vary_case(sb.pat_text[8*i +: 8]));
        end
        6, 7: chars.push_back(pick_alpha());
        default: chars.push_back(8'($urandom_range(255)));
      endcase
    end
    while (chars.size() > len) void'(chars.pop_back());
    for (i = 0; i < len; i++) send_char(chars[i], i == len - 1);
  endtask

  // fresh random settings, with junk in the unused data bits
  task automatic random_config(input int unsigned phase);
    logic [CfgDataW-1:0] pat;
    logic [LenW-1:0]     plen;
    logic [LenW-1:0]     rlen;
    int unsigned         i;
    for (i = 0; i < MaxPatternDef; i++) pat[8*i +: 8] = pick_alpha();
    case ($urandom_range(9))
      0: plen = 4'd0;
      1: plen = 4'd8;
      2: plen = 4'($urandom_range(9, 15));
      default: plen = 4'($urandom_range(1, 4));
    endcase
    if (phase == 0) plen = 4'd15;
    case ($urandom_range(5))
      0: rlen = 4'd0;
      1: rlen = 4'd8;
      2: rlen = 4'($urandom_range(9, 15));
      default: rlen = 4'($urandom_range(1, 4));
    endcase
    cfg_write(CFG_PATTERN_TEXT, pat);
    cfg_write(CFG_PATTERN_LENGTH, {$urandom, 28'($urandom), plen});
    cfg_write(CFG_REPLACEMENT_TEXT, {$urandom, $urandom});
    cfg_write(CFG_REPLACEMENT_LENGTH, {$urandom, 28'($urandom), rlen});
    cfg_write(CFG_MATCH_EXACT_CASE, {$urandom, $urandom});
    if ($urandom_range(3) == 0) cfg_write(CfgSpareIdx, {$urandom, $urandom});
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    sb          = new();
    calm        = 1'b0;
    hold_req    = 1'b0;
    items_sent  = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pattern is the single character zero, empty replacement,
    // so matched zeros vanish and a text ending in one leaves a bare end marker
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    settle();

    // spare indexes ignored; "Ab" folded against "aBAb", replaced by "xyz",
    // then a partial window flushed at the end
    cfg_write(CfgSpareIdx, '1);
    cfg_write(CfgSpareTopIdx, '1);
    cfg_write(CFG_PATTERN_TEXT, 64'h6241);
    cfg_write(CFG_PATTERN_LENGTH, 64'hA2);
    cfg_write(CFG_REPLACEMENT_TEXT, 64'h7A7978);
    cfg_write(CFG_REPLACEMENT_LENGTH, 64'h3);
    cfg_write(CFG_MATCH_EXACT_CASE, 64'h2);
    send_char(8'h61, 1'b0);
    send_char(8'h42, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h71, 1'b0);
    send_char(8'h61, 1'b1);
    settle();

    // exact compare, full length pattern with 00/ff and case-range edges,
    // oversized replacement length clamps to the full eight characters
    cfg_write(CFG_MATCH_EXACT_CASE, '1);
    cfg_write(CFG_PATTERN_TEXT, 64'h5A7A_405B_61FF_0041);
    cfg_write(CFG_PATTERN_LENGTH, 64'h8);
    cfg_write(CFG_REPLACEMENT_TEXT, 64'h07FF_0100_8055_AA01);
    cfg_write(CFG_REPLACEMENT_LENGTH, 64'hF);
    for (n = 0; n < MaxPatternDef; n++) send_char(sb.pat_text[8*n +: 8], 1'b0);
    for (n = 0; n < 5; n++) send_char(sb.pat_text[8*n +: 8], 1'b0);
    settle();

    // shorten the pattern with five characters still buffered: stale ones
    // drain one per word until the head matches, then the rest are dropped
    cfg_write(CFG_PATTERN_TEXT, 64'h5B61);
    cfg_write(CFG_PATTERN_LENGTH, 64'h2);
    send_char(8'h40, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h40, 1'b1);
    settle();

    // random settings and texts; phase one is a long text with no idling at
    // all, phase two runs into a long sink hold-off
    n = items_sent;
    phase = 0;
    while (items_sent < n + RandomItems) begin
      random_config(phase);
      calm = (phase == 1);
      if (phase == 1 || phase == 2) begin
        hold_req = (phase == 2);
        send_random_text(40);
      end else begin
        repeat ($urandom_range(1, 3)) send_random_text($urandom_range(1, 24));
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    $display("run covered %0d text words in %0d texts and %0d matches", items_sent,
             sb.texts, sb.match_cnt);
    $display("%0d rewritten words checked, %0d mismatches", sb.words_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("%0t: timeout with %0d words still owed", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/sfr_pkg.sv
design/sfr_cell.sv
design/sfr_burst.sv
design/stream_find_replace_all_top.sv
verif/tb_stream_find_replace_all_top.sv
